FILE: rtl/core/tpq_pkg.sv
package tpq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_GET    = 3'd1,
        OP_FINISH = 3'd2,
        OP_POP    = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    localparam int unsigned CNT_W  = 32;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned SLOT_W = 4;

    // s_tdata: func, item_value, slot_index
    localparam int unsigned S_DATA_W = 72;
    // m_tdata: ok, read_value, read_slot, head, mid, tail, stopped, consumer_ready
    localparam int unsigned M_DATA_W = 168;

    // result of one item, apart from the word that comes from the slot store
    typedef struct packed {
        logic              ok;
        logic              rd_en;
        logic [SLOT_W-1:0] read_slot;
        logic [CNT_W-1:0]  head_count;
        logic [CNT_W-1:0]  mid_count;
        logic [CNT_W-1:0]  tail_count;
        logic              stopped;
        logic              consumer_ready;
    } res_t;

endpackage

FILE: rtl/core/tpq_ram.sv
module tpq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/tpq_ctrl.sv
module tpq_ctrl
    import tpq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     op_fire,
    input  logic [2:0]               func,
    input  logic [WORD_W-1:0]        item_value,
    input  logic [SLOT_W-1:0]        slot_index,
    output res_t                     res,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [WORD_W-1:0]        ram_wdata,
    output logic                     ram_re,
    output logic [$clog2(DEPTH)-1:0] ram_raddr
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] mid_reg,  mid_next;
    logic [CNT_W-1:0] tail_reg, tail_next;
    logic [AW-1:0]    head_slot_reg, head_slot_next;
    logic [AW-1:0]    mid_slot_reg,  mid_slot_next;
    logic [AW-1:0]    tail_slot_reg, tail_slot_next;
    logic             stop_reg, stop_next;

    logic [CNT_W-1:0] fill, mid_gap, tail_gap, ready_gap;
    logic [CNT_W-1:0] sidx_w, mid_slot_w;
    logic             can_push, mid_behind, tail_behind, slot_ok;
    logic             ok;
    logic [SLOT_W-1:0] read_slot;

    // slot tracks count mod DEPTH; it restarts at 0 when the count wraps
    function automatic logic [AW-1:0] slot_adv(input logic [AW-1:0] slot,
                                               input logic [CNT_W-1:0] cnt);
        if (cnt == '1 || slot == AW'(DEPTH - 1)) begin
            return '0;
        end
        return slot + AW'(1);
    endfunction

    assign fill        = head_reg - tail_reg;
    assign mid_gap     = head_reg - mid_reg;
    assign tail_gap    = mid_reg - tail_reg;
    assign can_push    = fill < CNT_W'(DEPTH);
    assign mid_behind  = (mid_gap != '0) && !mid_gap[CNT_W-1];
    assign tail_behind = (tail_gap != '0) && !tail_gap[CNT_W-1];
    assign sidx_w      = CNT_W'(slot_index);
    assign slot_ok     = sidx_w < CNT_W'(DEPTH);
    assign mid_slot_w  = CNT_W'(mid_slot_reg);

    always_comb begin
        head_next      = head_reg;
        mid_next       = mid_reg;
        tail_next      = tail_reg;
        head_slot_next = head_slot_reg;
        mid_slot_next  = mid_slot_reg;
        tail_slot_next = tail_slot_reg;
        stop_next      = stop_reg;
        ok             = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = head_slot_reg;
        ram_wdata      = item_value;
        ram_re         = 1'b0;
        ram_raddr      = mid_slot_reg;
        read_slot      = '0;
        if (op_fire) begin
            unique case (func)
                OP_PUSH: begin
                    if (can_push) begin
                        ram_we         = 1'b1;
                        head_next      = head_reg + CNT_W'(1);
                        head_slot_next = slot_adv(head_slot_reg, head_reg);
                        ok             = 1'b1;
                    end
                end
                OP_GET: begin
                    if (mid_behind) begin
                        ram_re    = 1'b1;
                        read_slot = mid_slot_w[SLOT_W-1:0];
                        ok        = 1'b1;
                    end
                end
                OP_FINISH: begin
                    if (mid_behind && slot_ok) begin
                        ram_we        = 1'b1;
                        ram_waddr     = sidx_w[AW-1:0];
                        mid_next      = mid_reg + CNT_W'(1);
                        mid_slot_next = slot_adv(mid_slot_reg, mid_reg);
                        ok            = 1'b1;
                    end
                end
                OP_POP: begin
                    if (tail_behind) begin
                        ram_re         = 1'b1;
                        ram_raddr      = tail_slot_reg;
                        tail_next      = tail_reg + CNT_W'(1);
                        tail_slot_next = slot_adv(tail_slot_reg, tail_reg);
                        ok             = 1'b1;
                    end
                end
                OP_STOP: begin
                    stop_next = 1'b1;
                    ok        = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign ready_gap = head_next - mid_next;

    always_comb begin
        res.ok             = ok;
        res.rd_en          = ram_re;
        res.read_slot      = read_slot;
        res.head_count     = head_next;
        res.mid_count      = mid_next;
        res.tail_count     = tail_next;
        res.stopped        = stop_next;
        res.consumer_ready = (ready_gap != '0) && !ready_gap[CNT_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            mid_reg       <= '0;
            tail_reg      <= '0;
            head_slot_reg <= '0;
            mid_slot_reg  <= '0;
            tail_slot_reg <= '0;
            stop_reg      <= 1'b0;
        end else begin
            head_reg      <= head_next;
            mid_reg       <= mid_next;
            tail_reg      <= tail_next;
            head_slot_reg <= head_slot_next;
            mid_slot_reg  <= mid_slot_next;
            tail_slot_reg <= tail_slot_next;
            stop_reg      <= stop_next;
        end
    end

endmodule

FILE: rtl/core/three_pointer_ring_queue_unit.sv
// The item is held in the input register, then its result in the result register;
// the slot store read is registered into the same stage as the result.
// Throughput: one item per cycle while m_tready is high.
// Reset (aresetn low, synchronous): clears counters, stop flag and both valids;
// the slot store is not cleared.
module three_pointer_ring_queue_unit
    import tpq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] func, [66:3] item_value, [70:67] slot_index, [71] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] ok, [64:1] read_value, [68:65] read_slot, [100:69] head_count,
    // [132:101] mid_count, [164:133] tail_count, [165] stopped,
    // [166] consumer_ready, [167] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic              in_valid_reg, in_valid_next;
    logic [2:0]        in_func_reg;
    logic [WORD_W-1:0] in_value_reg;
    logic [SLOT_W-1:0] in_sidx_reg;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    logic              s_fire, advance, op_fire;
    res_t              res;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata, read_value;

    assign advance  = !out_valid_reg || m_tready;
    assign op_fire  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (op_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (op_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg  <= s_tdata[2:0];
            in_value_reg <= s_tdata[66:3];
            in_sidx_reg  <= s_tdata[70:67];
        end
        if (op_fire) begin
            out_res_reg <= res;
        end
    end

    tpq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_fire   (op_fire),
        .func      (in_func_reg),
        .item_value(in_value_reg),
        .slot_index(in_sidx_reg),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    // read data holds while the result waits, since no new read is issued
    tpq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_slot_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign read_value = out_res_reg.rd_en ? ram_rdata : '0;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {1'b0,
                         out_res_reg.consumer_ready,
                         out_res_reg.stopped,
                         out_res_reg.tail_count,
                         out_res_reg.mid_count,
                         out_res_reg.head_count,
                         out_res_reg.read_slot,
                         read_value,
                         out_res_reg.ok};

endmodule

FILE: rtl/core/tpq_checker.sv
module tpq_checker
    import tpq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled item changed");

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[165]) |=> (!m_tvalid || m_tdata[165]))
        else $error("stop flag cleared without reset");

    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == '0 && m_tdata[68:65] == '0))
        else $error("failed item carries read data");

    a_ready_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[166]) |-> (m_tdata[132:101] != m_tdata[100:69]))
        else $error("consumer ready with mid equal to head");

endmodule

bind three_pointer_ring_queue_unit tpq_checker u_tpq_checker (.*);

FILE: tb/three_pointer_ring_queue_unit_tb.sv
module three_pointer_ring_queue_unit_tb;
    import tpq_pkg::*;

    localparam int unsigned QDEPTH       = 16;
    localparam int unsigned QAW          = $clog2(QDEPTH);
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int unsigned IDLE_PCT     = 9;
    // funcs the block has no operation for
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] read_value;
        logic [SLOT_W-1:0] read_slot;
        logic [CNT_W-1:0]  head_count;
        logic [CNT_W-1:0]  mid_count;
        logic [CNT_W-1:0]  tail_count;
        logic              stopped;
        logic              consumer_ready;
    } qresult_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    three_pointer_ring_queue_unit #(.DEPTH(QDEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #4 aclk = ~aclk;

    logic [S_DATA_W-1:0] queued_ops[$];
    qresult_t            awaited_results[$];
    int                  fails = 0;
    int                  cycle = 0;

    // queue state as the block should hold it
    logic [WORD_W-1:0] slots [QDEPTH];
    logic [CNT_W-1:0]  q_head = '0;
    logic [CNT_W-1:0]  q_mid  = '0;
    logic [CNT_W-1:0]  q_tail = '0;
    logic              q_stop = 1'b0;

    // rough occupancy kept by the stimulus side, only to steer the mix
    int g_head = 0;
    int g_mid  = 0;
    int g_tail = 0;

    // a behind b: (b - a) mod 2^32 nonzero and below 2^31
    function automatic logic behind(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b);
        logic [CNT_W-1:0] d;
        d = b - a;
        return (d != '0) && !d[CNT_W-1];
    endfunction

    function automatic qresult_t apply_queue_op(input logic [S_DATA_W-1:0] item);
        logic [2:0]        f;
        logic [WORD_W-1:0] v;
        logic [SLOT_W-1:0] si;
        logic [CNT_W-1:0]  used;
        qresult_t          r;
        f    = item[2:0];
        v    = item[66:3];
        si   = item[70:67];
        used = q_head - q_tail;
        r    = '0;
        case (f)
            OP_PUSH: begin
                if (used < QDEPTH) begin
                    slots[QAW'(q_head % QDEPTH)] = v;
                    q_head = q_head + 1;
                    r.ok = 1'b1;
                end
            end
            OP_GET: begin
                if (behind(q_mid, q_head)) begin
                    r.read_value = slots[QAW'(q_mid % QDEPTH)];
                    r.read_slot  = SLOT_W'(q_mid % QDEPTH);
                    r.ok = 1'b1;
                end
            end
            OP_FINISH: begin
                // refused when it would pass the head or names a slot past the depth
                if (behind(q_mid, q_head) && si < QDEPTH) begin
                    slots[si] = v;
                    q_mid = q_mid + 1;
                    r.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (behind(q_tail, q_mid)) begin
                    r.read_value = slots[QAW'(q_tail % QDEPTH)];
                    q_tail = q_tail + 1;
                    r.ok = 1'b1;
                end
            end
            OP_STOP: begin
                q_stop = 1'b1;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.head_count     = q_head;
        r.mid_count      = q_mid;
        r.tail_count     = q_tail;
        r.stopped        = q_stop;
        r.consumer_ready = behind(q_mid, q_head);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    task automatic add_op(input logic [2:0] f, input logic [WORD_W-1:0] v,
                          input logic [SLOT_W-1:0] s);
        queued_ops.push_back({1'b0, s, v, f});
        case (f)
            OP_PUSH:   if (g_head - g_tail < QDEPTH) g_head++;
            OP_FINISH: if (g_mid < g_head) g_mid++;
            OP_POP:    if (g_tail < g_mid) g_tail++;
            default: ;
        endcase
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // both sides run without gaps for a while in the middle of the run
    wire quiet = (cycle >= 500) && (cycle < 900);

    always @(posedge aclk) begin
        cycle <= cycle + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (queued_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= queued_ops.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : monitor
        qresult_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_queue_op(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no item outstanding: %h", m_tdata);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("ok", WORD_W'(want.ok), WORD_W'(m_tdata[0]));
                    check_field("read_value", want.read_value, m_tdata[64:1]);
                    check_field("read_slot", WORD_W'(want.read_slot),
                                WORD_W'(m_tdata[68:65]));
                    check_field("head_count", WORD_W'(want.head_count),
                                WORD_W'(m_tdata[100:69]));
                    check_field("mid_count", WORD_W'(want.mid_count),
                                WORD_W'(m_tdata[132:101]));
                    check_field("tail_count", WORD_W'(want.tail_count),
                                WORD_W'(m_tdata[164:133]));
                    check_field("stopped", WORD_W'(want.stopped), WORD_W'(m_tdata[165]));
                    check_field("consumer_ready", WORD_W'(want.consumer_ready),
                                WORD_W'(m_tdata[166]));
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n;
        int mode;
        int pick;
        // empty queue: every reader and the worker are turned away
        add_op(OP_GET,    rand_word(), 4'h0);
        add_op(OP_POP,    rand_word(), 4'hf);
        add_op(OP_FINISH, '1,          4'hf);
        add_op(FUNC_SPARE_LO, '1, 4'ha);
        add_op(FUNC_SPARE_HI, '1, 4'h5);
        // fill to the brim, then one push too many
        add_op(OP_PUSH, '1, 4'h0);
        add_op(OP_PUSH, '0, 4'hf);
        for (int i = 0; i < QDEPTH - 2; i++) begin
            add_op(OP_PUSH, rand_word(), SLOT_W'($urandom));
        end
        add_op(OP_PUSH, rand_word(), 4'h3);
        add_op(OP_GET,    '0, 4'h0);
        add_op(OP_FINISH, 64'h5555_5555_5555_5555, 4'h0);
        add_op(OP_POP,    '0, 4'h0);
        // sticky from here on; nothing else is blocked by it
        add_op(OP_STOP,   rand_word(), 4'hc);

        n    = 0;
        mode = 0;
        while (queued_ops.size() < RANDOM_ITEMS) begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                add_op(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), rand_word(),
                       SLOT_W'($urandom));
            end else begin
                n++;
                if (pick < 6) begin
                    add_op(OP_STOP, rand_word(), SLOT_W'($urandom));
                end else if (pick < 10) begin
                    // worker step out of order
                    add_op(($urandom_range(0, 1) != 0) ? OP_GET : OP_FINISH, rand_word(),
                           SLOT_W'($urandom));
                end else begin
                    pick = $urandom_range(0, 99);
                    case (mode)
                        0:       pick = (pick < 55) ? 0 : (pick < 82) ? 1 : 2;
                        1:       pick = (pick < 15) ? 0 : (pick < 55) ? 1 : 2;
                        default: pick = (pick < 34) ? 0 : (pick < 67) ? 1 : 2;
                    endcase
                    if (pick == 0) begin
                        add_op(OP_PUSH, rand_word(), SLOT_W'($urandom));
                    end else if (pick == 1) begin
                        add_op(OP_GET, rand_word(), SLOT_W'($urandom));
                        if ($urandom_range(0, 99) < 85) begin
                            add_op(OP_FINISH, rand_word(), SLOT_W'(g_mid % QDEPTH));
                        end else begin
                            add_op(OP_FINISH, rand_word(), SLOT_W'($urandom));
                        end
                    end else begin
                        add_op(OP_POP, rand_word(), SLOT_W'($urandom));
                    end
                end
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_ops.size() != 0 || s_tvalid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
